// File: hdl/wfm2h_pkg.sv
// Shared constants, the command type and the blank-byte test for the filtered hash.
`timescale 1ns / 1ps

package wfm2h_pkg;

    localparam logic [31:0] HASH_MUL  = 32'h5bd1e995;
    localparam logic [31:0] HASH_SEED = 32'd1;

    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_SPACE = 8'h20;

    // One unit of work handed from the byte front end to the hash engine.
    // word holds a full group when absorb is set, otherwise the leftover tail.
    typedef struct packed {
        logic [31:0] word;
        logic        absorb;
        logic        finish;
        logic        tail_valid;
    } cmd_t;

    function automatic logic is_blank(input logic [7:0] b);
        return (b == CHAR_TAB) || (b == CHAR_LF) || (b == CHAR_CR) || (b == CHAR_SPACE);
    endfunction

endpackage

// File: hdl/whitespace_filtered_murmur2_hash.sv
// Top level of the whitespace-filtered MurmurHash2 fingerprint block.
`timescale 1ns / 1ps

// Usage
// The slave stream carries one raw message byte per item in s_tdata, with
// s_tuser saying whether that byte is present and s_tlast marking the item
// that ends the message. Tab, line feed, carriage return and space are
// dropped; the rest are hashed four at a time. On the last item one result
// item with the 32-bit fingerprint appears on the master stream.
// The configuration channel writes the count of kept bytes; the seed is one
// XOR that count. A write restarts the block and may only be issued when no
// message is in flight.
// Throughput: the front end takes one byte per cycle while the command queue
// has room. The engine works each group of four kept bytes in steps on its
// single shared multiplier (take, two key mixes, hash fold); finishing adds a
// tail mix when bytes are left over and the final avalanche. Sustained, this
// is about one byte per cycle on text with long runs of kept bytes, limited
// by the engine's group steps. The last item's command passes the queue to
// the engine, which runs the group steps if a group completes on that item,
// the tail mix if bytes are left over, then the avalanche into m_tdata.
// Reset clears the queue, the partial group and sets the seed to one.
// A stalled master holds its result; the engine waits at the finish step
// and the queue then fills, after which s_tready falls.

module whitespace_filtered_murmur2_hash
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic        clk,
    input  logic        rst_n,
    // slave stream: tdata[7:0] data_byte; tuser[0] byte_present; tlast is_final
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,
    input  logic        s_tuser,
    input  logic        s_tlast,
    // master stream: tdata[31:0] hash_value
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,
    // configuration: cfg_data[31:0] filtered_length
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_data
);
    import wfm2h_pkg::*;

    logic [31:0] len_reg;
    logic        cfg_write;
    logic        accept;
    logic        push;
    logic        pop;
    logic        q_full;
    logic        q_empty;
    cmd_t        push_cmd;
    cmd_t        head_cmd;

    // Configuration is always taken; it restarts front end, queue and engine.
    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    // The front end stalls only on a full queue or a configuration write.
    assign s_tready = !q_full && !cfg_write;
    assign accept   = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg <= 32'd0;
        end
        else if (cfg_write)
        begin
            len_reg <= cfg_data;
        end
    end

    wfm2h_front u_front
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .restart      (cfg_write),
        .accept       (accept),
        .data_byte    (s_tdata),
        .byte_present (s_tuser),
        .is_final     (s_tlast),
        .cmd_push     (push),
        .cmd          (push_cmd)
    );

    wfm2h_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk   (clk),
        .rst_n (rst_n),
        .flush (cfg_write),
        .push  (push),
        .din   (push_cmd),
        .pop   (pop),
        .dout  (head_cmd),
        .full  (q_full),
        .empty (q_empty)
    );

    // The engine reseeds from the stored length after each finished message,
    // and straight from the write data when the length is rewritten.
    wfm2h_back u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .restart      (cfg_write),
        .restart_seed (HASH_SEED ^ cfg_data),
        .seed         (HASH_SEED ^ len_reg),
        .cmd          (head_cmd),
        .cmd_avail    (!q_empty),
        .cmd_pop      (pop),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata)
    );

endmodule

// File: hdl/wfm2h_front.sv
// Front end: filters blank bytes, packs kept bytes into groups and issues commands.
`timescale 1ns / 1ps

module wfm2h_front
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               restart,
    input  logic               accept,
    input  logic [7:0]         data_byte,
    input  logic               byte_present,
    input  logic               is_final,
    output logic               cmd_push,
    output wfm2h_pkg::cmd_t    cmd
);
    import wfm2h_pkg::*;

    logic [23:0] pend_reg;
    logic [23:0] pend_next;
    logic [1:0]  cnt_reg;
    logic [1:0]  cnt_next;
    logic        kept;
    logic [23:0] merged;
    logic [1:0]  merged_cnt;
    logic        absorb;

    assign kept   = byte_present && !is_blank(data_byte);
    assign absorb = kept && (cnt_reg == 2'd3);

    always_comb
    begin
        merged     = pend_reg;
        merged_cnt = cnt_reg;
        if (kept)
        begin
            merged_cnt = cnt_reg + 2'd1;
            unique case (cnt_reg)
                2'd0:    merged = {16'd0, data_byte};
                2'd1:    merged = {8'd0, data_byte, pend_reg[7:0]};
                2'd2:    merged = {data_byte, pend_reg[15:0]};
                default: merged = 24'd0;
            endcase
        end
    end

    always_comb
    begin
        cmd.word       = absorb ? {data_byte, pend_reg} : {8'd0, merged};
        cmd.absorb     = absorb;
        cmd.finish     = is_final;
        cmd.tail_valid = is_final && !absorb && (merged_cnt != 2'd0);
        cmd_push       = accept && (absorb || is_final);
        pend_next      = is_final ? 24'd0 : merged;
        cnt_next       = is_final ? 2'd0 : merged_cnt;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= 24'd0;
            cnt_reg  <= 2'd0;
        end
        else if (restart)
        begin
            pend_reg <= 24'd0;
            cnt_reg  <= 2'd0;
        end
        else if (accept)
        begin
            pend_reg <= pend_next;
            cnt_reg  <= cnt_next;
        end
    end

    a_final_clears: assert property (@(posedge clk) disable iff (!rst_n)
        accept && is_final |=> cnt_reg == 2'd0)
        else $error("pending count not cleared after a final item");

endmodule

// File: hdl/wfm2h_queue.sv
// Short command queue between the front end and the hash engine.
`timescale 1ns / 1ps

module wfm2h_queue
#(
    parameter int DEPTH = 4
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            flush,
    input  logic            push,
    input  wfm2h_pkg::cmd_t din,
    input  logic            pop,
    output wfm2h_pkg::cmd_t dout,
    output logic            full,
    output logic            empty
);
    import wfm2h_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    cmd_t             entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    assign full  = (count_reg == CNT_W'(DEPTH));
    assign empty = (count_reg == '0);
    assign dout  = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push && !full)
        begin
            entry_reg[wr_ptr_reg] <= din;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else if (flush)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push && !full)
            begin
                wr_ptr_reg <= bump(wr_ptr_reg);
            end
            if (pop && !empty)
            begin
                rd_ptr_reg <= bump(rd_ptr_reg);
            end
            if ((push && !full) && !(pop && !empty))
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (!(push && !full) && (pop && !empty))
            begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("command pushed into a full queue");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue count beyond depth");

endmodule

// File: hdl/wfm2h_back.sv
// Hash engine: runs group mixes and the final avalanche on one shared multiplier.
`timescale 1ns / 1ps

module wfm2h_back
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            restart,
    input  logic [31:0]     restart_seed,
    input  logic [31:0]     seed,
    input  wfm2h_pkg::cmd_t cmd,
    input  logic            cmd_avail,
    output logic            cmd_pop,
    output logic            m_tvalid,
    input  logic            m_tready,
    output logic [31:0]     m_tdata
);
    import wfm2h_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_K1,
        S_K2,
        S_H,
        S_TAIL,
        S_FIN
    } state_t;

    state_t      state_reg;
    state_t      state_next;
    logic [31:0] h_reg;
    logic [31:0] h_next;
    logic [31:0] k_reg;
    logic [31:0] k_next;
    logic        fin_reg;
    logic        fin_next;
    logic        ovalid_reg;
    logic        ovalid_next;
    logic [31:0] odata_reg;
    logic [31:0] odata_next;
    logic [31:0] mul_a;
    logic [31:0] mul_p;
    logic        slot_free;

    assign slot_free = !ovalid_reg || m_tready;
    assign cmd_pop   = (state_reg == S_IDLE) && cmd_avail && !restart;
    assign mul_p     = mul_a * HASH_MUL;
    assign m_tvalid  = ovalid_reg;
    assign m_tdata   = odata_reg;

    always_comb
    begin
        unique case (state_reg)
            S_K1, S_K2: mul_a = k_reg;
            S_H:        mul_a = h_reg;
            S_TAIL:     mul_a = h_reg ^ k_reg;
            S_FIN:      mul_a = h_reg ^ (h_reg >> 13);
            default:    mul_a = 32'd0;
        endcase
    end

    always_comb
    begin
        state_next  = state_reg;
        h_next      = h_reg;
        k_next      = k_reg;
        fin_next    = fin_reg;
        ovalid_next = ovalid_reg && !m_tready;
        odata_next  = odata_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_pop)
                begin
                    k_next   = cmd.word;
                    fin_next = cmd.finish;
                    if (cmd.absorb)
                    begin
                        state_next = S_K1;
                    end
                    else if (cmd.tail_valid)
                    begin
                        state_next = S_TAIL;
                    end
                    else
                    begin
                        state_next = S_FIN;
                    end
                end
            end
            S_K1:
            begin
                k_next     = mul_p ^ (mul_p >> 24);
                state_next = S_K2;
            end
            S_K2:
            begin
                k_next     = mul_p;
                state_next = S_H;
            end
            S_H:
            begin
                h_next     = mul_p ^ k_reg;
                state_next = fin_reg ? S_FIN : S_IDLE;
            end
            S_TAIL:
            begin
                h_next     = mul_p;
                state_next = S_FIN;
            end
            S_FIN:
            begin
                if (slot_free)
                begin
                    odata_next  = mul_p ^ (mul_p >> 15);
                    ovalid_next = 1'b1;
                    h_next      = seed;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        if (restart)
        begin
            state_next = S_IDLE;
            h_next     = restart_seed;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            h_reg      <= HASH_SEED;
            k_reg      <= 32'd0;
            fin_reg    <= 1'b0;
            ovalid_reg <= 1'b0;
            odata_reg  <= 32'd0;
        end
        else
        begin
            state_reg  <= state_next;
            h_reg      <= h_next;
            k_reg      <= k_next;
            fin_reg    <= fin_next;
            ovalid_reg <= ovalid_next;
            odata_reg  <= odata_next;
        end
    end

    a_pop_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_pop |-> state_reg == S_IDLE && cmd_avail)
        else $error("command taken while the engine was busy");

    a_fin_emits: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_FIN && slot_free && !restart |=> ovalid_reg && state_reg == S_IDLE)
        else $error("finished hash not presented");

endmodule

// File: sim/whitespace_filtered_murmur2_hash_tb.sv
// Self-checking testbench for the whitespace-filtered MurmurHash2 fingerprint block.
`timescale 1ns / 1ps

module whitespace_filtered_murmur2_hash_tb;

    import wfm2h_pkg::*;

    localparam int SETTLE_CYCLES = 20;    // covers the worst last-item latency with margin
    localparam int STALL_LIMIT   = 4000;  // cycles with no handshake before giving up
    localparam int HOLD_CYCLES   = 500;   // long receiver hold-off in the pressure phase
    localparam int PHASE_ITEMS   = 200;

    // Empty message with the reset length of zero: seed 1 run through the avalanche.
    localparam logic [31:0] EMPTY_HASH = 32'h5bd15e36;

    typedef struct packed {
        logic [7:0] data;
        logic       present;
        logic       is_last;
    } item_t;

    typedef struct packed {
        logic [7:0]  data;
        logic        present;
        logic        is_last;
        logic        typed;
        logic [31:0] hash;
    } dir_row_t;

    localparam int DIR_ROWS = 23;
    localparam dir_row_t DIR_TAB [DIR_ROWS] = '{
        '{8'h00, 1'b0, 1'b1, 1'b1, EMPTY_HASH},   // empty message
        '{CHAR_TAB,   1'b1, 1'b0, 1'b0, 32'h0},
        '{CHAR_LF,    1'b1, 1'b0, 1'b0, 32'h0},
        '{CHAR_CR,    1'b1, 1'b0, 1'b0, 32'h0},
        '{CHAR_SPACE, 1'b1, 1'b0, 1'b0, 32'h0},
        '{8'h00, 1'b0, 1'b1, 1'b1, EMPTY_HASH},   // blanks only hash as empty
        '{8'h41, 1'b0, 1'b0, 1'b0, 32'h0},        // no byte: data must be ignored
        '{8'h00, 1'b1, 1'b1, 1'b0, 32'h0},        // byte and end of message together
        '{8'hFF, 1'b1, 1'b0, 1'b0, 32'h0},
        '{8'h80, 1'b1, 1'b0, 1'b0, 32'h0},
        '{8'h7F, 1'b1, 1'b0, 1'b0, 32'h0},
        '{8'h01, 1'b1, 1'b0, 1'b0, 32'h0},        // completes a group
        '{CHAR_SPACE, 1'b1, 1'b0, 1'b0, 32'h0},
        '{8'h61, 1'b1, 1'b0, 1'b0, 32'h0},
        '{CHAR_LF,    1'b1, 1'b1, 1'b0, 32'h0},   // blank on the last item, one byte left over
        '{8'h30, 1'b1, 1'b0, 1'b0, 32'h0},
        '{8'h31, 1'b1, 1'b0, 1'b0, 32'h0},
        '{8'h32, 1'b1, 1'b0, 1'b0, 32'h0},
        '{8'h00, 1'b0, 1'b1, 1'b0, 32'h0},        // three bytes left over
        '{8'h41, 1'b1, 1'b0, 1'b0, 32'h0},
        '{8'h42, 1'b1, 1'b0, 1'b0, 32'h0},
        '{8'h43, 1'b1, 1'b0, 1'b0, 32'h0},
        '{8'h44, 1'b1, 1'b1, 1'b0, 32'h0}         // group completes on the last item
    };

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;     // [7:0] data_byte
    logic        s_tuser;     // [0] byte_present
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;     // [31:0] hash_value
    logic        cfg_valid;
    logic        cfg_ready;
    logic [31:0] cfg_data;

    whitespace_filtered_murmur2_hash dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Fingerprint predictor state.
    logic [31:0] length_reg;
    logic [31:0] run_hash;
    logic [23:0] tail_bytes;
    logic [1:0]  tail_cnt;

    logic [31:0] hash_q [$];
    item_t       msg_q [$];
    int          msg_kept;

    int mismatches    = 0;
    int items_sent    = 0;
    int hashes_seen   = 0;
    int length_writes = 0;
    int src_idle_pct  = 0;
    int snk_stall_pct = 0;
    int hold_req      = 0;
    int hold_served   = 0;
    int hold_left     = 0;
    int quiet_cycles  = 0;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch at %0t: %s, got %08h, expected %08h", $time, what, got, want);
        mismatches++;
    endtask

    function automatic logic is_ws(input logic [7:0] b);
        return (b == CHAR_TAB) || (b == CHAR_LF) || (b == CHAR_CR) || (b == CHAR_SPACE);
    endfunction

    task automatic reload_seed();
        run_hash   = HASH_SEED ^ length_reg;
        tail_bytes = '0;
        tail_cnt   = '0;
    endtask

    // Advances the fingerprint by one item and gives the finished hash on the last one.
    task automatic predict_fingerprint(input item_t it, output logic emits,
                                       output logic [31:0] hash);
        logic [31:0] k;
        logic [31:0] h;
        if (it.present && !is_ws(it.data))
        begin
            if (tail_cnt == 2'd3)
            begin
                k = {it.data, tail_bytes} * HASH_MUL;
                k = k ^ (k >> 24);
                k = k * HASH_MUL;
                run_hash   = (run_hash * HASH_MUL) ^ k;
                tail_bytes = '0;
                tail_cnt   = '0;
            end
            else
            begin
                tail_bytes[8*tail_cnt +: 8] = it.data;
                tail_cnt = tail_cnt + 2'd1;
            end
        end
        emits = it.is_last;
        hash  = '0;
        if (it.is_last)
        begin
            h = run_hash;
            if (tail_cnt != 2'd0)
            begin
                h = (h ^ {8'h00, tail_bytes}) * HASH_MUL;
            end
            h = h ^ (h >> 13);
            h = h * HASH_MUL;
            h = h ^ (h >> 15);
            hash = h;
            reload_seed();
        end
    endtask

    // Offers one item, holding it until accepted; a typed hash overrides the prediction.
    task automatic offer_item(input item_t it, input logic typed, input logic [31:0] typed_hash);
        logic        emits;
        logic [31:0] h;
        if ($urandom_range(99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < src_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= it.data;
        s_tuser  <= it.present;
        s_tlast  <= it.is_last;
        do @(posedge clk); while (!s_tready);
        predict_fingerprint(it, emits, h);
        items_sent++;
        if (emits)
        begin
            hash_q.push_back(typed ? typed_hash : h);
        end
    endtask

    task automatic write_length(input logic [31:0] v);
        cfg_data  <= v;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        length_reg = v;
        reload_seed();
        length_writes++;
    endtask

    // Waits for every outstanding hash, then lets the engine drain.
    task automatic settle();
        s_tvalid <= 1'b0;
        while (hash_q.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Builds one message: mostly short, a few long, with blanks and byte-less items mixed in.
    task automatic build_message();
        int    n;
        int    r;
        item_t it;
        msg_q.delete();
        msg_kept = 0;
        n = ($urandom_range(9) == 0) ? $urandom_range(64) : $urandom_range(10);
        for (int i = 0; i <= n; i++)
        begin
            it.data    = 8'($urandom_range(255));
            it.present = 1'b1;
            it.is_last = (i == n);
            r = $urandom_range(99);
            if (it.is_last)
            begin
                it.present = 1'($urandom_range(1));
            end
            else if (r < 10)
            begin
                it.present = 1'b0;
            end
            else if (r < 30)
            begin
                case ($urandom_range(3))
                    0: it.data = CHAR_TAB;
                    1: it.data = CHAR_LF;
                    2: it.data = CHAR_CR;
                    default: it.data = CHAR_SPACE;
                endcase
            end
            if (it.present && !is_ws(it.data))
            begin
                msg_kept++;
            end
            msg_q.push_back(it);
        end
    endtask

    // One phase: a length setting, an idling mix, and whole messages until the item budget.
    // With matched set, each message is preceded by a write of its true kept-byte count.
    task automatic run_phase(input logic [31:0] len, input int src_pct, input int snk_pct,
                             input logic matched, input logic pressure);
        int sent;
        settle();
        write_length(len);
        src_idle_pct  = src_pct;
        snk_stall_pct = snk_pct;
        if (pressure)
        begin
            hold_req++;
        end
        sent = 0;
        while (sent < PHASE_ITEMS)
        begin
            build_message();
            if (matched)
            begin
                settle();
                write_length(32'(msg_kept));
            end
            foreach (msg_q[i])
            begin
                offer_item(msg_q[i], 1'b0, '0);
            end
            sent += msg_q.size();
        end
    endtask

    // Receiver: checks each accepted hash against the oldest expectation and drives m_tready.
    always @(posedge clk)
    begin : sink
        logic [31:0] want;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                if (hash_q.size() == 0)
                begin
                    report_mismatch("hash with none expected", m_tdata, '0);
                end
                else
                begin
                    want = hash_q.pop_front();
                    if (m_tdata !== want)
                    begin
                        report_mismatch("hash_value", m_tdata, want);
                    end
                    hashes_seen++;
                end
            end
            if (hold_left > 0)
            begin
                hold_left <= hold_left - 1;
                m_tready  <= 1'b0;
            end
            else if (hold_served != hold_req)
            begin
                hold_served <= hold_req;
                hold_left   <= HOLD_CYCLES;
                m_tready    <= 1'b0;
            end
            else
            begin
                m_tready <= ($urandom_range(99) >= snk_stall_pct);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
                $display("FAIL");
                $finish;
            end
        end
    end

    initial
    begin
        item_t row_item;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= 1'b0;
        s_tlast   <= 1'b0;
        m_tready  <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_data  <= '0;
        length_reg = '0;
        reload_seed();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed rows run at the reset length with no idling.
        for (int i = 0; i < DIR_ROWS; i++)
        begin
            row_item = '{DIR_TAB[i].data, DIR_TAB[i].present, DIR_TAB[i].is_last};
            offer_item(row_item, DIR_TAB[i].typed, DIR_TAB[i].hash);
        end

        run_phase(32'hFFFF_FFFF, 0, 0, 1'b0, 1'b0);
        run_phase(32'h0000_0000, 82, 0, 1'b0, 1'b0);
        run_phase($urandom(), 0, 82, 1'b0, 1'b0);
        run_phase(32'($urandom_range(64)), 18, 18, 1'b0, 1'b0);
        run_phase(32'h0000_0000, 18, 18, 1'b1, 1'b0);
        run_phase(32'h7FFF_FFFF, 0, 0, 1'b0, 1'b1);

        settle();
        if (hash_q.size() != 0)
        begin
            report_mismatch($sformatf("%0d hashes never arrived", hash_q.size()), '0, hash_q[0]);
        end
        $display("run covered %0d items and %0d checked hashes over %0d length settings,",
                 items_sent, hashes_seen, length_writes);
        $display("with idle sender, stalled receiver, a long hold-off and matched lengths");
        if (mismatches == 0)
        begin
            $display("PASS");
        end
        else
        begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// File: sim.f
hdl/wfm2h_pkg.sv
hdl/wfm2h_front.sv
hdl/wfm2h_queue.sv
hdl/wfm2h_back.sv
hdl/whitespace_filtered_murmur2_hash.sv
sim/whitespace_filtered_murmur2_hash_tb.sv
